// ----- sv/pstep_pkg.sv -----
// Shared types, widths and reset constants of the two-axis step generator.
`default_nettype none

package pstep_pkg;

  // Step counter width; the ratio accumulator and the ramp threshold follow from it.
  localparam int CountBits = 16;
  localparam int AccW      = 2 * CountBits;
  localparam int StepsW    = 16;
  localparam int AbsW      = StepsW + 1;
  localparam int ThrW      = ((CountBits > 16) ? CountBits : 16) + 1;

  localparam int DelayW    = 16;
  localparam int RampStepW = 10;
  localparam int WindowW   = 16;
  localparam int CfgDataW  = 16;
  localparam int CfgIdxW   = 2;

  localparam int InDataW   = 2 * StepsW;
  localparam int OutDataW  = 8;

  localparam logic [DelayW-1:0]    StartDelayRst = DelayW'(2500);
  localparam logic [DelayW-1:0]    MinDelayRst   = DelayW'(900);
  localparam logic [RampStepW-1:0] RampStepRst   = RampStepW'(10);
  localparam logic [WindowW-1:0]   RampWindowRst = WindowW'(250);
  localparam logic [DelayW-1:0]    DelayMax      = {DelayW{1'b1}};

  typedef enum logic [CfgIdxW-1:0] {
    CfgStartDelay = 2'd0,
    CfgMinDelay   = 2'd1,
    CfgRampStep   = 2'd2,
    CfgRampWindow = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    ActStart = 1'b0,
    ActTick  = 1'b1
  } action_e;

  // One result item.
  typedef struct packed {
    logic done_res;
    logic busy_res;
    logic selector_dir;
    logic idler_dir;
    logic selector_pulse;
    logic idler_pulse;
  } res_t;

endpackage

`default_nettype wire

// ----- sv/pstep_core.sv -----
// Move state, ratio accumulator and delay ramp: one item per enabled cycle.
`default_nettype none

module pstep_core
  import pstep_pkg::*;
(
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  wire [CfgIdxW-1:0]   cfg_index_i,
  input  wire [CfgDataW-1:0]  cfg_data_i,
  input  wire                 step_en_i,
  input  wire                 action_i,
  input  wire [StepsW-1:0]    idler_steps_i,
  input  wire [StepsW-1:0]    selector_steps_i,
  output res_t                res_o
);

  logic [DelayW-1:0]    start_delay_q, min_delay_q;
  logic [RampStepW-1:0] ramp_step_q;
  logic [WindowW-1:0]   ramp_window_q;

  logic [CountBits-1:0] idler_left_q, idler_left_d;
  logic [CountBits-1:0] sel_left_q, sel_left_d;
  logic [AccW-1:0]      acc_q, acc_d;
  logic [CountBits-1:0] den_q, den_d;
  logic [CountBits-1:0] inc_q, inc_d;
  logic [DelayW-1:0]    delay_q, delay_d;
  logic [DelayW-1:0]    wait_q, wait_d;
  logic signed [ThrW-1:0] thr_q, thr_d;
  logic idir_q, idir_d, sdir_q, sdir_d, moving_q, moving_d;

  logic [AbsW-1:0]      idler_abs, sel_abs;
  logic [CountBits-1:0] idler_new, sel_new, sel_dec;
  logic [DelayW-1:0]    wait_dec, delay_dn, delay_shr;
  logic [DelayW:0]      delay_sum;
  logic                 reached, ip, sp, done;

  // Register file writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_delay_q <= StartDelayRst;
      min_delay_q   <= MinDelayRst;
      ramp_step_q   <= RampStepRst;
      ramp_window_q <= RampWindowRst;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CfgStartDelay: start_delay_q <= DelayW'(cfg_data_i);
        CfgMinDelay:   min_delay_q   <= DelayW'(cfg_data_i);
        CfgRampStep:   ramp_step_q   <= cfg_data_i[RampStepW-1:0];
        CfgRampWindow: ramp_window_q <= WindowW'(cfg_data_i);
        default:       ;
      endcase
    end
  end

  // Magnitudes of the start counts.
  assign idler_abs = idler_steps_i[StepsW-1] ?
                     (AbsW'(0) - {idler_steps_i[StepsW-1], idler_steps_i}) :
                     {1'b0, idler_steps_i};
  assign sel_abs   = selector_steps_i[StepsW-1] ?
                     (AbsW'(0) - {selector_steps_i[StepsW-1], selector_steps_i}) :
                     {1'b0, selector_steps_i};
  assign idler_new = CountBits'(idler_abs);
  assign sel_new   = CountBits'(sel_abs);

  assign wait_dec = (wait_q != '0) ? wait_q - DelayW'(1) : wait_q;
  assign reached  = acc_q >= AccW'(den_q);
  assign ip       = reached && (idler_left_q != '0);
  assign sp       = sel_left_q != '0;
  assign sel_dec  = sp ? sel_left_q - CountBits'(1) : sel_left_q;

  // Ramp: shorten near the start of the count, lengthen near its end.
  always_comb begin
    delay_dn = delay_q;
    if ((delay_q > min_delay_q) && ($signed(ThrW'(sel_dec)) > thr_q)) begin
      delay_dn = (delay_q >= DelayW'(ramp_step_q)) ? delay_q - DelayW'(ramp_step_q) : '0;
    end
    delay_sum = {1'b0, delay_dn} + (DelayW + 1)'(ramp_step_q);
    delay_shr = delay_dn;
    if ((delay_dn < start_delay_q) && (ThrW'(sel_dec) < ThrW'(ramp_window_q))) begin
      delay_shr = delay_sum[DelayW] ? DelayMax : delay_sum[DelayW-1:0];
    end
  end

  always_comb begin
    idler_left_d = idler_left_q;
    sel_left_d   = sel_left_q;
    acc_d        = acc_q;
    den_d        = den_q;
    inc_d        = inc_q;
    delay_d      = delay_q;
    wait_d       = wait_q;
    thr_d        = thr_q;
    idir_d       = idir_q;
    sdir_d       = sdir_q;
    moving_d     = moving_q;
    done         = 1'b0;
    res_o        = '0;
    if (step_en_i) begin
      if (action_e'(action_i) == ActStart) begin
        idir_d       = ~idler_steps_i[StepsW-1];
        sdir_d       = ~selector_steps_i[StepsW-1];
        idler_left_d = idler_new;
        sel_left_d   = sel_new;
        den_d        = (sel_new != '0) ? sel_new : CountBits'(1);
        inc_d        = (sel_new != '0) ? idler_new : CountBits'(1);
        acc_d        = '0;
        delay_d      = start_delay_q;
        wait_d       = '0;
        thr_d        = $signed(ThrW'(sel_new)) - $signed(ThrW'(ramp_window_q));
        moving_d     = (idler_new != '0) || (sel_new != '0);
        done         = (idler_new == '0) && (sel_new == '0);
      end else if (moving_q) begin
        wait_d = wait_dec;
        if (wait_dec == '0) begin
          if ((idler_left_q == '0) && (sel_left_q == '0)) begin
            moving_d = 1'b0;
            done     = 1'b1;
          end else begin
            res_o.idler_pulse    = ip;
            res_o.selector_pulse = sp;
            idler_left_d = ip ? idler_left_q - CountBits'(1) : idler_left_q;
            sel_left_d   = sel_dec;
            acc_d        = (reached ? acc_q - AccW'(den_q) : acc_q) + AccW'(inc_q);
            wait_d       = delay_q;
            delay_d      = delay_shr;
          end
        end
      end
    end
    res_o.idler_dir    = idir_d;
    res_o.selector_dir = sdir_d;
    res_o.busy_res     = moving_d;
    res_o.done_res     = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idler_left_q <= '0;
      sel_left_q   <= '0;
      acc_q        <= '0;
      den_q        <= CountBits'(1);
      inc_q        <= '0;
      delay_q      <= StartDelayRst;
      wait_q       <= '0;
      thr_q        <= '0;
      idir_q       <= 1'b1;
      sdir_q       <= 1'b1;
      moving_q     <= 1'b0;
    end else begin
      idler_left_q <= idler_left_d;
      sel_left_q   <= sel_left_d;
      acc_q        <= acc_d;
      den_q        <= den_d;
      inc_q        <= inc_d;
      delay_q      <= delay_d;
      wait_q       <= wait_d;
      thr_q        <= thr_d;
      idir_q       <= idir_d;
      sdir_q       <= sdir_d;
      moving_q     <= moving_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/pstep_out_buf.sv -----
// Two-entry result buffer between the step logic and the output channel.
`default_nettype none

module pstep_out_buf
  import pstep_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        push_i,
  input  wire res_t  push_data_i,
  output logic       not_full_o,
  output logic       valid_o,
  input  wire        ready_i,
  output res_t       data_o
);

  res_t       ent_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign pop        = valid_o && ready_i;
  assign valid_o    = cnt_q != 2'd0;
  assign not_full_o = cnt_q != 2'd2;
  assign data_o     = ent_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop);
    end
  end

endmodule

`default_nettype wire

// ----- sv/proportional_two_axis_stepper_top.sv -----
// Top level of the two-axis proportional step generator with a linear ramp.
//
// Input channel (s_axis_*): tuser is the action, 0 starts a move with the
// signed counts in tdata, 1 is a one microsecond tick. Each item gives one
// result item on m_axis_*: step pulses for both axes, the latched directions,
// busy and done.
// Configuration channel (cfg_*): index selects start delay, minimum delay,
// ramp step or ramp window; always ready. The user must write it only while
// idle; the block itself does not enforce this.
// Path: an accepted item is held in the input register until the result
// buffer has room, then the step logic updates the move state and writes
// the result into a two-entry buffer, from which m_axis_* shows it.
// Throughput: one item per clock while the result buffer has room; the step
// logic updates its move state as each item advances.
// Stall: while the output is stalled the buffer holds results; with both
// entries full the input register holds its item and s_axis_tready drops.
// Reset: configuration returns to 2500/900/10/250, no move is running and
// both directions read as non-negative.
`default_nettype none

module proportional_two_axis_stepper_top
  import pstep_pkg::*;
(
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  wire [InDataW-1:0]   s_axis_tdata_i,   // idler_steps, selector_steps
  input  wire                 s_axis_tuser_i,   // action
  output logic                m_axis_tvalid_o,
  input  wire                 m_axis_tready_i,
  // idler_pulse, selector_pulse, idler_dir, selector_dir, busy_res, done_res, 2'b0
  output logic [OutDataW-1:0] m_axis_tdata_o,
  input  wire                 cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire [CfgIdxW-1:0]   cfg_index_i,
  input  wire [CfgDataW-1:0]  cfg_data_i
);

  logic               in_vld_q;
  logic               in_act_q;
  logic [StepsW-1:0]  in_idler_q, in_sel_q;
  logic               buf_not_full;
  logic               advance;
  res_t               core_res, out_res;

  assign cfg_ready_o     = 1'b1;
  // Advance the held item into the step logic when the buffer has room.
  assign advance         = in_vld_q && buf_not_full;
  assign s_axis_tready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_act_q   <= s_axis_tuser_i;
      in_idler_q <= s_axis_tdata_i[StepsW-1:0];
      in_sel_q   <= s_axis_tdata_i[InDataW-1:StepsW];
    end
  end

  pstep_core u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .step_en_i        (advance),
    .action_i         (in_act_q),
    .idler_steps_i    (in_idler_q),
    .selector_steps_i (in_sel_q),
    .res_o            (core_res)
  );

  pstep_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (advance),
    .push_data_i (core_res),
    .not_full_o  (buf_not_full),
    .valid_o     (m_axis_tvalid_o),
    .ready_i     (m_axis_tready_i),
    .data_o      (out_res)
  );

  // Pack result fields from the lowest bit up, pad to a whole byte.
  assign m_axis_tdata_o = {2'b00, out_res.done_res, out_res.busy_res,
                           out_res.selector_dir, out_res.idler_dir,
                           out_res.selector_pulse, out_res.idler_pulse};

endmodule

`default_nettype wire

// ----- sv/pstep_chk.sv -----
// Port-level checks of the step generator and their binding to the top level.
`default_nettype none

module pstep_chk
  import pstep_pkg::*;
(
  input wire                clk_i,
  input wire                rst_ni,
  input wire                m_axis_tvalid_o,
  input wire                m_axis_tready_i,
  input wire [OutDataW-1:0] m_axis_tdata_o
);

  // A completing item leaves no move running.
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[5]) |-> !m_axis_tdata_o[4])
    else $error("done with busy set");

  // A step pulse only comes from a running move.
  a_pulse_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tdata_o[0] || m_axis_tdata_o[1])) |-> m_axis_tdata_o[4])
    else $error("step pulse while not busy");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("stalled result changed");

endmodule

bind proportional_two_axis_stepper_top pstep_chk u_pstep_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire

// ----- bench/tb_top.sv -----
// Self-checking bench for the two-axis proportional step generator with a linear ramp.
//
// What is tested: moves started from signed idler and selector counts and advanced
// one microsecond per tick, with the step pulses, the latched directions, busy and
// done checked item by item against a cycle-free model of the move kept below.
//
// How: an initial block plans the run in phases. Each phase programs the four ramp
// registers while nothing is in flight, then fills a queue of input items. A clocked
// driver offers those items at the falling edge with random gaps. A sampler at the
// rising edge runs the model on every accepted input and queues the outcome. A
// clocked monitor pops the oldest outcome for every accepted result and compares
// field by field. The receiver stalls at random, and once holds off for a long
// stretch while the sender floods the block. A watchdog ends the run when nothing
// moves for too long.
//
// Coverage intent: empty moves, restarts over a running move, ticks with no move,
// idler-only moves, idler steps left after the selector ran out, the delay floor at
// zero, the delay ceiling at 65535, and some register extremes.
`default_nettype none

module tb_top;
  import pstep_pkg::*;

  localparam int QuietLimit = 2000;   // cycles with no handshake before giving up
  localparam int LongHoldoff = 150;   // receiver hold-off that fills the block
  localparam int PrintCap = 100;      // mismatch lines printed, the rest only counted

  typedef struct {
    action_e                   act;
    logic signed [StepsW-1:0]  idler;
    logic signed [StepsW-1:0]  selector;
  } motion_item_t;

  // Clock and reset.
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  // Block ports; every input starts at a known value.
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [InDataW-1:0]   s_axis_tdata_i = '0;   // idler_steps, selector_steps
  logic                 s_axis_tuser_i = 1'b0; // action
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  // idler_pulse, selector_pulse, idler_dir, selector_dir, busy_res, done_res, 2'b0
  logic [OutDataW-1:0]  m_axis_tdata_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i = '0;
  logic [CfgDataW-1:0]  cfg_data_i = '0;

  proportional_two_axis_stepper_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  // Items waiting to be offered; the front one is on the bus while tvalid is high.
  motion_item_t move_items_q[$];
  // Outcomes of accepted items, oldest first.
  res_t         step_results_q[$];

  int  mismatch_count = 0;
  bit  item_taken = 1'b0;      // set at the rising edge, consumed by the driver
  bit  result_taken = 1'b0;    // set at the rising edge, consumed by the receiver
  bit  sender_idle_en = 1'b1;
  bit  recv_idle_en = 1'b1;
  bit  long_stall_req = 1'b0;
  int  send_gap = 0;
  int  recv_gap = 0;
  int  quiet_cycles = 0;

  // ---------------------------------------------------------------------------
  // Move model: ramp registers and move state as they stand after reset.
  // ---------------------------------------------------------------------------
  logic [DelayW-1:0]     start_delay_cfg = StartDelayRst;
  logic [DelayW-1:0]     min_delay_cfg   = MinDelayRst;
  logic [RampStepW-1:0]  ramp_step_cfg   = RampStepRst;
  logic [WindowW-1:0]    ramp_window_cfg = RampWindowRst;

  logic [StepsW-1:0]     idler_remaining = '0;
  logic [StepsW-1:0]     selector_remaining = '0;
  logic [AccW-1:0]       ratio_acc = '0;
  logic [StepsW-1:0]     ratio_den = 16'd1;
  logic [StepsW-1:0]     ratio_inc = '0;
  logic [DelayW-1:0]     delay_now = StartDelayRst;
  logic [DelayW-1:0]     wait_count = '0;
  logic signed [ThrW-1:0] accel_edge = '0;
  logic                  idler_fwd = 1'b1;
  logic                  selector_fwd = 1'b1;
  logic                  move_active = 1'b0;

  // Advance the move by one input item and return the result it produces.
  function automatic res_t advance_motion(motion_item_t it);
    res_t                r;
    int                  iv;
    int                  sv;
    logic                reached;
    logic [DelayW:0]     grown;
    r = '0;
    if (it.act == ActStart) begin
      iv = int'(it.idler);
      sv = int'(it.selector);
      idler_fwd = (iv >= 0);
      selector_fwd = (sv >= 0);
      idler_remaining = StepsW'(iv < 0 ? -iv : iv);
      selector_remaining = StepsW'(sv < 0 ? -sv : sv);
      if (selector_remaining != 0) begin
        ratio_den = selector_remaining;
        ratio_inc = idler_remaining;
      end else begin
        // selector idle: idler alone, one step per iteration after the first
        ratio_den = 16'd1;
        ratio_inc = 16'd1;
      end
      ratio_acc = '0;
      delay_now = start_delay_cfg;
      wait_count = '0;
      accel_edge = $signed({1'b0, selector_remaining}) - $signed({1'b0, ramp_window_cfg});
      if (idler_remaining == 0 && selector_remaining == 0) begin
        move_active = 1'b0;
        r.done_res = 1'b1;
      end else begin
        move_active = 1'b1;
      end
    end else if (move_active) begin
      if (wait_count != 0) wait_count--;
      if (wait_count == 0) begin
        if (idler_remaining == 0 && selector_remaining == 0) begin
          move_active = 1'b0;
          r.done_res = 1'b1;
        end else begin
          reached = (ratio_acc >= AccW'(ratio_den));
          if (reached && idler_remaining != 0) begin
            r.idler_pulse = 1'b1;
            idler_remaining--;
          end
          if (selector_remaining != 0) begin
            r.selector_pulse = 1'b1;
            selector_remaining--;
          end
          if (reached) ratio_acc -= AccW'(ratio_den);
          ratio_acc += AccW'(ratio_inc);
          // the wait uses the delay in force before this iteration's ramp update
          wait_count = delay_now;
          if (delay_now > min_delay_cfg &&
              $signed({1'b0, selector_remaining}) > accel_edge) begin
            delay_now = (delay_now >= DelayW'(ramp_step_cfg)) ?
                        delay_now - DelayW'(ramp_step_cfg) : '0;
          end
          if (delay_now < start_delay_cfg && selector_remaining < ramp_window_cfg) begin
            grown = {1'b0, delay_now} + (DelayW+1)'(ramp_step_cfg);
            delay_now = (grown > {1'b0, DelayMax}) ? DelayMax : grown[DelayW-1:0];
          end
        end
      end
    end
    r.idler_dir = idler_fwd;
    r.selector_dir = selector_fwd;
    r.busy_res = move_active;
    return r;
  endfunction

  // Print one mismatch line (up to a cap) and count it.
  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= PrintCap)
      $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Input side: offer items at the falling edge, predict on acceptance.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (item_taken) begin
      item_taken = 1'b0;
      send_gap = sender_idle_en ? $urandom_range(0, 9) : 0;
    end
    // hold the current item until taken; idle for the drawn gap after each item
    if (send_gap != 0) begin
      send_gap--;
      s_axis_tvalid_i <= 1'b0;
    end else if (move_items_q.size() != 0) begin
      s_axis_tvalid_i <= 1'b1;
      s_axis_tdata_i <= {move_items_q[0].selector, move_items_q[0].idler};
      s_axis_tuser_i <= move_items_q[0].act;
    end else begin
      s_axis_tvalid_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      step_results_q.push_back(advance_motion(move_items_q[0]));
      void'(move_items_q.pop_front());
      item_taken = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Output side: stall at random, compare every accepted result.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (result_taken) begin
      result_taken = 1'b0;
      recv_gap = recv_idle_en ? $urandom_range(0, 9) : 0;
    end
    // a long hold-off lets the result buffer fill so the input side stalls
    if (long_stall_req) begin
      long_stall_req = 1'b0;
      recv_gap = LongHoldoff;
    end
    if (recv_gap != 0) begin
      recv_gap--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      result_taken = 1'b1;
      got = res_t'(m_axis_tdata_o[5:0]);
      if (step_results_q.size() == 0) begin
        report_mismatch("result with nothing pending", int'(m_axis_tdata_o), 0);
      end else begin
        want = step_results_q.pop_front();
        if (got.idler_pulse !== want.idler_pulse)
          report_mismatch("idler_pulse", int'(got.idler_pulse), int'(want.idler_pulse));
        if (got.selector_pulse !== want.selector_pulse)
          report_mismatch("selector_pulse", int'(got.selector_pulse),
                          int'(want.selector_pulse));
        if (got.idler_dir !== want.idler_dir)
          report_mismatch("idler_dir", int'(got.idler_dir), int'(want.idler_dir));
        if (got.selector_dir !== want.selector_dir)
          report_mismatch("selector_dir", int'(got.selector_dir), int'(want.selector_dir));
        if (got.busy_res !== want.busy_res)
          report_mismatch("busy_res", int'(got.busy_res), int'(want.busy_res));
        if (got.done_res !== want.done_res)
          report_mismatch("done_res", int'(got.done_res), int'(want.done_res));
      end
    end
  end

  // Watchdog: end the run when no channel has moved an item for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i) || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus planning.
  // ---------------------------------------------------------------------------
  function automatic int rand_count(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic push_start(input int idler, input int selector);
    motion_item_t it;
    it.act = ActStart;
    it.idler = StepsW'(idler);
    it.selector = StepsW'(selector);
    move_items_q.push_back(it);
  endtask

  // Ticks carry random counts, which the block must ignore.
  task automatic push_ticks(input int n);
    motion_item_t it;
    repeat (n) begin
      it.act = ActTick;
      it.idler = StepsW'($urandom);
      it.selector = StepsW'($urandom);
      move_items_q.push_back(it);
    end
  endtask

  // Wait until every item is taken and every result checked, let the pipeline
  // settle, and come back on a rising edge.
  task automatic wait_idle();
    do @(negedge clk_i); while (move_items_q.size() != 0 || step_results_q.size() != 0);
    repeat (4) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Write all four ramp registers and mirror them into the model.
  task automatic load_ramp(input logic [DelayW-1:0] start_us, input logic [DelayW-1:0] min_us,
                           input logic [RampStepW-1:0] step_us,
                           input logic [WindowW-1:0] window);
    cfg_reg_e           idx;
    logic [CfgDataW-1:0] val;
    for (int k = 0; k < 4; k++) begin
      idx = cfg_reg_e'(k);
      case (idx)
        CfgStartDelay: val = start_us;
        CfgMinDelay:   val = min_us;
        CfgRampStep:   val = CfgDataW'(step_us);
        default:       val = window;
      endcase
      @(negedge clk_i);
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i <= val;
      do @(posedge clk_i); while (!cfg_ready_o);
      case (idx)
        CfgStartDelay: start_delay_cfg = val;
        CfgMinDelay:   min_delay_cfg = val;
        CfgRampStep:   ramp_step_cfg = val[RampStepW-1:0];
        default:       ramp_window_cfg = val;
      endcase
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly complete moves with small counts; some abandoned midway, some with
  // full-range counts, some stray ticks.
  task automatic queue_random_moves(input int n_items, input int span, input int tick_cap);
    int queued;
    int pick;
    int ia;
    int sa;
    int ticks;
    queued = 0;
    while (queued < n_items) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        push_start(int'($urandom), int'($urandom));
        ticks = $urandom_range(0, 6);
      end else if (pick == 1) begin
        ticks = $urandom_range(1, 8);
      end else begin
        ia = rand_count(span);
        sa = rand_count(span);
        push_start(ia, sa);
        ticks = ((ia < 0 ? -ia : ia) > (sa < 0 ? -sa : sa) ? (ia < 0 ? -ia : ia) :
                 (sa < 0 ? -sa : sa)) + 3;
        ticks = ticks * (int'(start_delay_cfg) + int'(ramp_step_cfg) + 1);
        if ($urandom_range(0, 7) == 0) ticks = $urandom_range(0, ticks);
      end
      if (ticks > tick_cap) ticks = tick_cap;
      push_ticks(ticks);
      queued += ticks + ((pick != 1) ? 1 : 0);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset configuration: idle tick, empty move, extreme counts,
    // restart over a running move, idler-only move.
    push_ticks(1);
    push_start(0, 0);
    push_start(32767, -32768);
    push_ticks(2);
    push_start(-32768, 32767);
    push_ticks(1);
    push_start(-1, 0);
    push_ticks(2);
    wait_idle();

    // Directed, one tick per iteration: idler-only move to completion, and an
    // idler step left over after the selector has run out.
    load_ramp(16'd1, 16'd1, 10'd1, 16'd2);
    push_start(2, 0);
    push_ticks(4);
    push_start(-1, 3);
    push_ticks(5);
    wait_idle();

    // Random phases, each under its own ramp setting.
    for (int phase = 0; phase < 8; phase++) begin
      sender_idle_en = ($urandom_range(0, 3) != 0);
      recv_idle_en = ($urandom_range(0, 3) != 0);
      case (phase)
        2: load_ramp(16'd1, 16'd1, 10'd0, 16'd0);
        4: load_ramp(16'd8, 16'd1, 10'd1023, 16'd32768);
        5: load_ramp(16'd65535, 16'd65535, 10'd1023, 16'd32768);
        7: load_ramp(16'd6, 16'd65535, 10'd3, 16'd3);
        default: load_ramp(DelayW'($urandom_range(1, 6)), DelayW'($urandom_range(1, 6)),
                           RampStepW'($urandom_range(0, 3)),
                           WindowW'($urandom_range(0, 8)));
      endcase
      if (phase == 6) begin
        // flood the input while the output is held off
        sender_idle_en = 1'b0;
        long_stall_req = 1'b1;
      end
      queue_random_moves(60, (phase == 4 || phase == 5) ? 3 : 5,
                         (phase == 4 || phase == 5) ? 20 : 400);
      wait_idle();
    end

    // Delay floor: the first ramp update drives the delay to zero, then it grows
    // back by a full step; run the move to completion.
    sender_idle_en = 1'b0;
    recv_idle_en = 1'b0;
    load_ramp(16'd8, 16'd1, 10'd20, 16'd32768);
    push_start(0, 2);
    push_ticks(40);
    wait_idle();

    // Delay ceiling: raise the start delay after the move has latched its first
    // delay, so the growth on the first iteration clamps at 65535; then drop the
    // move with an empty start.
    load_ramp(16'd64600, 16'd65535, 10'd1023, 16'd32768);
    push_start(0, 3);
    wait_idle();
    load_ramp(16'd65535, 16'd65535, 10'd1023, 16'd32768);
    push_ticks(100);
    push_start(0, 0);
    wait_idle();

    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && step_results_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
